FILE: rtl/core/p2r_pkg.sv
// Package for the polar to rectangular converter: sizes, word types,
// the arctangent table and the inverse gain constant.
// No dependencies.
`timescale 1ns / 1ps

package p2r_pkg;

    localparam int ANGLE_BITS      = 16;
    localparam int MAG_BITS        = 16;
    localparam int ROTATION_STAGES = 16;
    localparam int USED_STAGES     = (ROTATION_STAGES > 32) ? 32 : ROTATION_STAGES;
    localparam int OUT_BITS        = MAG_BITS + 1;
    localparam int GUARD_BITS      = 30;
    localparam int GAIN_BITS       = 30;
    localparam int PHASE_BITS      = 32;
    localparam int DATA_BITS       = MAG_BITS + GUARD_BITS + 2;
    localparam int ROUND_BITS      = DATA_BITS - GUARD_BITS;

    typedef logic signed [DATA_BITS-1:0]  t_data;
    typedef logic signed [PHASE_BITS-1:0] t_phase;
    typedef logic [1:0]                   t_quad;

    localparam t_quad QUAD_ZERO  = 2'd0;
    localparam t_quad QUAD_ONE   = 2'd1;
    localparam t_quad QUAD_TWO   = 2'd2;
    localparam t_quad QUAD_THREE = 2'd3;

    typedef struct packed {
        t_quad  quad;
        t_data  x;
        t_data  y;
        t_phase z;
    } t_rot;

    localparam t_phase ATAN_TURN32 [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // The rotation gain in Q30, the square root of the product of the
    // stage gains, evaluated at elaboration.
    function automatic logic [63:0] cordic_gain_q30();
        logic [63:0] p;
        logic [63:0] n;
        logic [63:0] root;
        logic [63:0] bit_v;
        p = 64'd1 << (2 * GUARD_BITS);
        for (int i = 0; i < USED_STAGES; i++) begin
            p = p + (p >> (2 * i));
        end
        n     = p;
        root  = 64'd0;
        bit_v = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (bit_v > n) begin
                bit_v = bit_v >> 2;
            end
        end
        for (int j = 0; j < 32; j++) begin
            if (bit_v != 64'd0) begin
                if (n >= root + bit_v) begin
                    n    = n - (root + bit_v);
                    root = (root >> 1) + bit_v;
                end else begin
                    root = root >> 1;
                end
                bit_v = bit_v >> 2;
            end
        end
        if (root == 64'd0) begin
            root = 64'd1;
        end
        return root;
    endfunction

    localparam logic [63:0] GAIN_Q30 = cordic_gain_q30();
    localparam logic [GAIN_BITS-1:0] INV_GAIN =
        GAIN_BITS'((64'd1 << (2 * GUARD_BITS)) / GAIN_Q30);

endpackage

FILE: rtl/core/p2r_rotator.sv
// Pipelined shift-add rotation: one register stage per rotation step.
// Depends on p2r_pkg.
`timescale 1ns / 1ps

module p2r_rotator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  p2r_pkg::t_rot i_word,
    output logic          o_valid,
    output p2r_pkg::t_rot o_word
);
    import p2r_pkg::*;

    logic r_valid [USED_STAGES];
    t_rot r_word  [USED_STAGES];

    for (genvar g = 0; g < USED_STAGES; g++) begin : g_stage
        logic stage_valid;
        t_rot stage_in;
        t_rot n_word;

        if (g == 0) begin : g_first
            assign stage_valid = i_valid;
            assign stage_in    = i_word;
        end else begin : g_next
            assign stage_valid = r_valid[g-1];
            assign stage_in    = r_word[g-1];
        end

        always_comb begin
            n_word.quad = stage_in.quad;
            if (!stage_in.z[PHASE_BITS-1]) begin
                n_word.x = stage_in.x - (stage_in.y >>> g);
                n_word.y = stage_in.y + (stage_in.x >>> g);
                n_word.z = stage_in.z - ATAN_TURN32[g];
            end else begin
                n_word.x = stage_in.x + (stage_in.y >>> g);
                n_word.y = stage_in.y - (stage_in.x >>> g);
                n_word.z = stage_in.z + ATAN_TURN32[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else begin
                r_valid[g] <= stage_valid;
            end
            r_word[g] <= n_word;
        end
    end

    assign o_valid = r_valid[USED_STAGES-1];
    assign o_word  = r_word[USED_STAGES-1];

endmodule

FILE: rtl/core/polar_to_rectangular.sv
// Top level of the polar to rectangular converter (CORDIC rotation).
// Depends on p2r_pkg and p2r_rotator.
//
//   channel  | handshake        | fields
//   ---------+------------------+---------------------------
//   input    | start, busy      | i_magnitude, i_angle
//   result   | o_done (strobe)  | o_real_part, o_imag_part
//
// A word enters on any cycle with start high; busy stays low.
// Each result passes through one multiply stage, one stage per rotation step,
// quadrant mapping and rounding.
// Synchronous active-low reset clears the valid bits of every stage.
// The result strobe lasts one cycle and the receiver cannot stall it.
`timescale 1ns / 1ps

module polar_to_rectangular (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [p2r_pkg::MAG_BITS-1:0]        i_magnitude,
    input  logic [p2r_pkg::ANGLE_BITS-1:0]      i_angle,
    output logic                                o_done,
    output logic signed [p2r_pkg::OUT_BITS-1:0] o_real_part,
    output logic signed [p2r_pkg::OUT_BITS-1:0] o_imag_part
);
    import p2r_pkg::*;

    localparam logic signed [ROUND_BITS-1:0] LIM_POS =
        ROUND_BITS'((64'd1 << MAG_BITS) - 64'd1);
    localparam logic signed [ROUND_BITS-1:0] LIM_NEG = -LIM_POS;

    logic [PHASE_BITS-1:0]          phase;
    logic [MAG_BITS+GAIN_BITS-1:0]  prod;
    t_rot                           n_in;
    logic                           r_in_valid;
    t_rot                           r_in;

    logic                           rot_valid;
    t_rot                           rot_word;

    t_data                          n_map_x;
    t_data                          n_map_y;
    logic                           r_map_valid;
    t_data                          r_map_x;
    t_data                          r_map_y;

    t_data                          sum_x;
    t_data                          sum_y;
    logic signed [ROUND_BITS-1:0]   rnd_x;
    logic signed [ROUND_BITS-1:0]   rnd_y;
    logic signed [OUT_BITS-1:0]     n_real;
    logic signed [OUT_BITS-1:0]     n_imag;
    logic                           r_done;
    logic signed [OUT_BITS-1:0]     r_real;
    logic signed [OUT_BITS-1:0]     r_imag;

    assign busy = 1'b0;

    always_comb begin
        phase  = PHASE_BITS'(i_angle) << (PHASE_BITS - ANGLE_BITS);
        prod   = i_magnitude * INV_GAIN;
        n_in.quad = phase[PHASE_BITS-1 -: 2] + t_quad'(phase[PHASE_BITS-3]);
        n_in.x    = DATA_BITS'(prod);
        n_in.y    = '0;
        n_in.z    = t_phase'(signed'(phase[PHASE_BITS-3:0]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
        r_in <= n_in;
    end

    p2r_rotator u_rotator (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_word  (r_in),
        .o_valid (rot_valid),
        .o_word  (rot_word)
    );

    always_comb begin
        unique case (rot_word.quad)
            QUAD_ONE: begin
                n_map_x = -rot_word.y;
                n_map_y = rot_word.x;
            end
            QUAD_TWO: begin
                n_map_x = -rot_word.x;
                n_map_y = -rot_word.y;
            end
            QUAD_THREE: begin
                n_map_x = rot_word.y;
                n_map_y = -rot_word.x;
            end
            default: begin
                n_map_x = rot_word.x;
                n_map_y = rot_word.y;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_valid <= 1'b0;
        end else begin
            r_map_valid <= rot_valid;
        end
        r_map_x <= n_map_x;
        r_map_y <= n_map_y;
    end

    always_comb begin
        sum_x = r_map_x + (t_data'(1) <<< (GUARD_BITS - 1));
        sum_y = r_map_y + (t_data'(1) <<< (GUARD_BITS - 1));
        rnd_x = signed'(sum_x[DATA_BITS-1:GUARD_BITS]);
        rnd_y = signed'(sum_y[DATA_BITS-1:GUARD_BITS]);
        if (rnd_x > LIM_POS) begin
            n_real = OUT_BITS'(LIM_POS);
        end else if (rnd_x < LIM_NEG) begin
            n_real = OUT_BITS'(LIM_NEG);
        end else begin
            n_real = OUT_BITS'(rnd_x);
        end
        if (rnd_y > LIM_POS) begin
            n_imag = OUT_BITS'(LIM_POS);
        end else if (rnd_y < LIM_NEG) begin
            n_imag = OUT_BITS'(LIM_NEG);
        end else begin
            n_imag = OUT_BITS'(rnd_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_map_valid;
        end
        r_real <= n_real;
        r_imag <= n_imag;
    end

    assign o_done      = r_done;
    assign o_real_part = r_real;
    assign o_imag_part = r_imag;

endmodule
